### src/rfa_pkg.sv
// Package: operation codes, widths and queue types for the register file ALU.
`default_nettype none
package rfa_pkg;
  localparam int DATA_W = 32;
  localparam int IDX_W = 4;
  localparam int MODE_W = 4;
  localparam int NUM_REGS_DEF = 16;

  localparam logic [MODE_W-1:0] OP_ADD = 4'd0;
  localparam logic [MODE_W-1:0] OP_SUB = 4'd1;
  localparam logic [MODE_W-1:0] OP_MUL = 4'd2;
  localparam logic [MODE_W-1:0] OP_DIV = 4'd3;
  localparam logic [MODE_W-1:0] OP_AND = 4'd4;
  localparam logic [MODE_W-1:0] OP_OR = 4'd5;
  localparam logic [MODE_W-1:0] OP_XOR = 4'd6;
  localparam logic [MODE_W-1:0] OP_MOV = 4'd7;
  localparam logic [MODE_W-1:0] OP_CMP = 4'd8;
  localparam logic [MODE_W-1:0] OP_WRITE = 4'd9;
  localparam logic [MODE_W-1:0] OP_READ = 4'd10;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0] dest_index;
    logic [IDX_W-1:0] src_index;
    logic [DATA_W-1:0] write_value;
    logic is_div;
  } cmd_t;
endpackage
`default_nettype wire

### src/rfa_front.sv
// Front end: accepts and classifies commands; a two-entry queue holds one at a time.
`default_nettype none
module rfa_front import rfa_pkg::*; (
  input wire clk,
  input wire rst,
  input wire start,
  input wire [MODE_W-1:0] mode,
  input wire [IDX_W-1:0] dest_index,
  input wire [IDX_W-1:0] src_index,
  input wire [DATA_W-1:0] write_value,
  output logic busy,
  output logic q_valid,
  output cmd_t q_cmd,
  input wire q_pop
);
  cmd_t slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push;

  assign push = start && !busy;
  // one item in flight keeps the register read order exact
  assign busy = (count != 2'd0);
  assign q_valid = (count != 2'd0);
  assign q_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{mode: mode, dest_index: dest_index, src_index: src_index,
                        write_value: write_value, is_div: (mode == OP_DIV)};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

### src/rfa_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module rfa_div import rfa_pkg::*; (
  input wire clk,
  input wire rst,
  input wire go,
  input wire [DATA_W-1:0] dividend,
  input wire [DATA_W-1:0] divisor,
  output logic done,
  output logic [DATA_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DATA_W + 1);
  logic [DATA_W-1:0] rem, quo, dvs;
  logic [CNT_W-1:0] cnt;
  logic running;
  logic [DATA_W:0] trial;

  assign trial = {rem, quo[DATA_W-1]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt <= CNT_W'(DATA_W);
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
      end else if (running) begin
        if (trial[DATA_W]) begin
          rem <= {rem[DATA_W-2:0], quo[DATA_W-1]};
          quo <= {quo[DATA_W-2:0], 1'b0};
        end else begin
          rem <= trial[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### src/rfa_back.sv
// Back end: register file, flags, ALU sequencer and result strobe.
`default_nettype none
module rfa_back import rfa_pkg::*; #(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input wire clk,
  input wire rst,
  input wire q_valid,
  input cmd_t q_cmd,
  output logic q_pop,
  output logic done,
  output logic [DATA_W-1:0] result_value,
  output logic zero_flag,
  output logic sign_flag,
  output logic overflow_flag,
  output logic divide_error
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [DATA_W-1:0] regs [NUM_REGS];
  logic [NUM_REGS-1:0] valid;
  logic [2:0] state;
  logic zb, sb, ob;
  logic [DATA_W-1:0] a, b;
  logic [2*DATA_W-1:0] prod;
  logic neg;
  logic div_go, div_done;
  logic [DATA_W-1:0] div_q;
  logic in_a, in_b;
  logic [IDX_W-1:0] di, si;
  logic [AW-1:0] da, sa;

  assign di = q_cmd.dest_index;
  assign si = q_cmd.src_index;
  assign da = AW'(di);
  assign sa = AW'(si);
  assign in_a = ({28'd0, di} < 32'(NUM_REGS));
  assign in_b = ({28'd0, si} < 32'(NUM_REGS));

  rfa_div u_div (
    .clk(clk), .rst(rst), .go(div_go),
    .dividend(a[DATA_W-1] ? -a : a), .divisor(b[DATA_W-1] ? -b : b),
    .done(div_done), .quotient(div_q)
  );

  assign div_go = (state == S_DIV);

  always_ff @(posedge clk) begin
    logic [DATA_W-1:0] res;
    logic wr, zs;
    logic ov;
    logic fin;
    res = '0;
    wr = 1'b0;
    zs = 1'b0;
    ov = ob;
    fin = 1'b0;
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      zb <= 1'b0;
      sb <= 1'b0;
      ob <= 1'b0;
      done <= 1'b0;
      q_pop <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid && !q_pop) begin
            a <= (in_a && valid[da]) ? regs[da] : '0;
            b <= (in_b && valid[sa]) ? regs[sa] : '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          divide_error <= q_cmd.is_div && (b == '0);
          case (q_cmd.mode)
            OP_ADD: begin
              res = a + b; ov = (a[31] ^ res[31]) & (b[31] ^ res[31]);
              wr = 1'b1; zs = 1'b1;
            end
            OP_SUB, OP_CMP: begin
              res = a - b; ov = (a[31] ^ b[31]) & (a[31] ^ res[31]);
              wr = (q_cmd.mode == OP_SUB); zs = 1'b1;
            end
            OP_AND, OP_OR, OP_XOR: begin
              res = (q_cmd.mode == OP_AND) ? (a & b) :
                    (q_cmd.mode == OP_OR) ? (a | b) : (a ^ b);
              ov = 1'b0; wr = 1'b1; zs = 1'b1;
            end
            OP_MOV: begin res = b; wr = 1'b1; end
            OP_WRITE: begin res = q_cmd.write_value; wr = 1'b1; end
            OP_READ: res = a;
            default: res = '0;
          endcase
          if (q_cmd.mode == OP_MUL) begin
            prod <= $signed(a) * $signed(b);
            state <= S_MUL;
          end else if (q_cmd.is_div) begin
            if (b == '0) begin
              res = '0;
            end else begin
              neg <= a[31] ^ b[31];
              state <= S_DIV;
            end
          end
          if (q_cmd.mode != OP_MUL && !(q_cmd.is_div && b != '0)) begin
            state <= S_IDLE;
            fin = 1'b1;
          end
        end
        S_MUL: begin
          res = prod[DATA_W-1:0];
          ov = (prod[2*DATA_W-1:DATA_W-1] != '0) && (prod[2*DATA_W-1:DATA_W-1] != '1);
          wr = 1'b1; zs = 1'b1;
          state <= S_IDLE; fin = 1'b1;
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            res = neg ? -div_q : div_q;
            ov = 1'b0; wr = 1'b1; zs = 1'b1;
            state <= S_IDLE; fin = 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      done <= fin;
      q_pop <= fin;
      if (zs) begin
        zb <= (res == '0);
        sb <= res[31];
        ob <= ov;
      end
      if (wr && in_a) begin
        regs[da] <= res;
        valid[da] <= 1'b1;
      end
      if (state == S_EXEC || state == S_MUL || (state == S_DIVW && div_done)) begin
        result_value <= res;
        zero_flag <= zs ? (res == '0) : zb;
        sign_flag <= zs ? res[31] : sb;
        overflow_flag <= zs ? ov : ob;
      end
    end
  end
endmodule
`default_nettype wire

### src/register_file_alu_with_flags.sv
// Top level of the register file ALU with status flags.
// Command channel: a beat is taken at a clock edge with start high and busy low.
// mode, dest_index, src_index and write_value form the beat.
// Result channel: done is high for one cycle with result_value and the flags;
// the receiver cannot stall it.
// One command is in flight at a time. From accept to done a command passes the
//   front queue slot, the operand read in S_IDLE and S_EXEC, which ends add,
//   sub, logic, mov, cmp, write, read and divide by zero; mul goes on to S_MUL
//   (registered multiply) and div to S_DIV and S_DIVW (one quotient bit per
//   cycle in the divider).
// busy stays high from accept through the result strobe cycle and drops in the
// cycle after it, so the next beat can be taken in the cycle after the strobe.
// Reset clears the internal flag state and marks every register as zero through
// valid bits; no clearing pass is needed.
`default_nettype none
module register_file_alu_with_flags import rfa_pkg::*; #(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input wire clk,
  input wire rst,
  input wire start,
  output logic busy,
  input wire [MODE_W-1:0] mode,
  input wire [IDX_W-1:0] dest_index,
  input wire [IDX_W-1:0] src_index,
  input wire signed [DATA_W-1:0] write_value,
  output logic done,
  output logic signed [DATA_W-1:0] result_value,
  output logic zero_flag,
  output logic sign_flag,
  output logic overflow_flag,
  output logic divide_error
);
  logic q_valid, q_pop;
  cmd_t q_cmd;

  rfa_front u_front (
    .clk(clk), .rst(rst), .start(start), .mode(mode), .dest_index(dest_index),
    .src_index(src_index), .write_value(write_value), .busy(busy),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  rfa_back #(.NUM_REGS(NUM_REGS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .done(done), .result_value(result_value), .zero_flag(zero_flag),
    .sign_flag(sign_flag), .overflow_flag(overflow_flag), .divide_error(divide_error)
  );
endmodule
`default_nettype wire

### tb/sv/register_file_alu_with_flags_tb.sv
// Testbench for the register file ALU: queued command driver, strobe monitor, flag/register predictor.
`timescale 1ns / 1ps
module register_file_alu_with_flags_tb;
  import rfa_pkg::*;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0] dest_index;
    logic [IDX_W-1:0] src_index;
    logic [DATA_W-1:0] write_value;
  } alu_cmd_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic zf;
    logic sf;
    logic vf;
    logic derr;
  } alu_res_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [MODE_W-1:0] mode = '0;
  logic [IDX_W-1:0] dest_index = '0;
  logic [IDX_W-1:0] src_index = '0;
  logic signed [DATA_W-1:0] write_value = '0;
  wire busy;
  wire done;
  wire signed [DATA_W-1:0] result_value;
  wire zero_flag, sign_flag, overflow_flag, divide_error;

  register_file_alu_with_flags dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .dest_index(dest_index), .src_index(src_index),
    .write_value(write_value), .done(done), .result_value(result_value),
    .zero_flag(zero_flag), .sign_flag(sign_flag), .overflow_flag(overflow_flag),
    .divide_error(divide_error)
  );

  alu_cmd_t pending_cmds[$];
  alu_res_t expected_results[$];
  logic [DATA_W-1:0] model_regs [NUM_REGS_DEF];
  logic model_z, model_s, model_v;
  int mismatches = 0;
  int idle_pct = 0;
  logic running = 0;

  function automatic logic [DATA_W-1:0] reg_rd(logic [IDX_W-1:0] i);
    return (i < NUM_REGS_DEF) ? model_regs[i] : '0;
  endfunction

  function automatic alu_res_t alu_predict(alu_cmd_t c);
    alu_res_t o;
    logic [DATA_W-1:0] a, b, r, ua, ub, q;
    logic signed [63:0] p;
    logic wr;
    a = reg_rd(c.dest_index);
    b = reg_rd(c.src_index);
    r = '0;
    wr = 0;
    o.derr = 0;
    case (c.mode)
      OP_ADD: begin
        r = a + b; model_v = (a[31] ^ r[31]) & (b[31] ^ r[31]); wr = 1;
        model_z = (r == 0); model_s = r[31];
      end
      OP_SUB, OP_CMP: begin
        r = a - b; model_v = (a[31] ^ b[31]) & (a[31] ^ r[31]); wr = (c.mode == OP_SUB);
        model_z = (r == 0); model_s = r[31];
      end
      OP_MUL: begin
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        r = p[31:0]; model_v = (p > 64'sd2147483647) || (p < -64'sd2147483648);
        model_z = (r == 0); model_s = r[31]; wr = 1;
      end
      OP_DIV: begin
        if (b == 0) begin
          o.derr = 1;
        end else begin
          ua = a[31] ? -a : a;
          ub = b[31] ? -b : b;
          q = ua / ub;
          r = (a[31] ^ b[31]) ? -q : q;
          model_v = 0; model_z = (r == 0); model_s = r[31]; wr = 1;
        end
      end
      OP_AND, OP_OR, OP_XOR: begin
        r = (c.mode == OP_AND) ? (a & b) : (c.mode == OP_OR) ? (a | b) : (a ^ b);
        model_v = 0; model_z = (r == 0); model_s = r[31]; wr = 1;
      end
      OP_MOV: begin
        r = b; wr = 1;
      end
      OP_WRITE: begin
        r = c.write_value; wr = 1;
      end
      OP_READ: r = a;
      default: r = '0;
    endcase
    if (wr && c.dest_index < NUM_REGS_DEF) model_regs[c.dest_index] = r;
    o.value = r; o.zf = model_z; o.sf = model_s; o.vf = model_v;
    return o;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4: return $urandom_range(0, 20);
      5: return -$urandom_range(1, 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_cmd(int m, int d, int s, logic [DATA_W-1:0] v);
    alu_cmd_t c;
    c.mode = MODE_W'(m); c.dest_index = IDX_W'(d); c.src_index = IDX_W'(s);
    c.write_value = v;
    pending_cmds.push_back(c);
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || expected_results.size() != 0 || busy || start)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (running && start && !busy) begin
      expected_results.push_back(alu_predict(pending_cmds.pop_front()));
    end
    if (running && pending_cmds.size() > 0 &&
        !(start && busy) && $urandom_range(0, 99) >= idle_pct) begin
      alu_cmd_t c;
      c = pending_cmds[0];
      start <= 1;
      mode <= c.mode; dest_index <= c.dest_index;
      src_index <= c.src_index; write_value <= c.write_value;
    end else if (!(start && busy)) begin
      start <= 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat value=%h", result_value);
      end else begin
        alu_res_t e;
        e = expected_results.pop_front();
        if (result_value !== e.value || zero_flag !== e.zf || sign_flag !== e.sf ||
            overflow_flag !== e.vf || divide_error !== e.derr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp v=%h z%b s%b o%b de%b got v=%h z%b s%b o%b de%b",
                     e.value, e.zf, e.sf, e.vf, e.derr, result_value, zero_flag,
                     sign_flag, overflow_flag, divide_error);
        end
      end
    end
  end

  initial begin
    int ph, n;
    for (int i = 0; i < NUM_REGS_DEF; i++) model_regs[i] = '0;
    model_z = 0; model_s = 0; model_v = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    running = 1;
    push_cmd(OP_WRITE, 1, 0, 32'h8000_0000);
    push_cmd(OP_WRITE, 2, 0, 32'hffff_ffff);
    push_cmd(OP_WRITE, 3, 0, 32'h7fff_ffff);
    push_cmd(OP_WRITE, 4, 0, 32'd7);
    push_cmd(OP_WRITE, 5, 0, -32'sd2);
    push_cmd(OP_DIV, 4, 0, 0);
    push_cmd(OP_DIV, 4, 5, 0);
    push_cmd(OP_WRITE, 6, 0, 32'h8000_0000);
    push_cmd(OP_DIV, 6, 2, 0);
    push_cmd(OP_ADD, 3, 3, 0);
    push_cmd(OP_SUB, 1, 4, 0);
    push_cmd(OP_MUL, 2, 2, 0);
    push_cmd(OP_WRITE, 7, 0, 32'h0001_0000);
    push_cmd(OP_MUL, 7, 7, 0);
    push_cmd(OP_AND, 5, 2, 0);
    push_cmd(OP_OR, 5, 4, 0);
    push_cmd(OP_XOR, 5, 5, 0);
    push_cmd(OP_MOV, 8, 1, 0);
    push_cmd(OP_CMP, 8, 1, 0);
    push_cmd(OP_READ, 8, 0, 0);
    push_cmd(OP_READ, 15, 15, 0);
    push_cmd(11, 0, 0, 0);
    push_cmd(15, 15, 15, 32'hffff_ffff);
    drain();
    for (ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 3) ? 12 : 83;
      for (n = 0; n < 200; n++) begin
        if ($urandom_range(0, 3) == 0)
          push_cmd(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15), pick_value());
        else if ($urandom_range(0, 19) == 0)
          push_cmd($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom);
        else
          push_cmd($urandom_range(0, 10), $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom);
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

### sim.f
src/rfa_pkg.sv
src/rfa_front.sv
src/rfa_div.sv
src/rfa_back.sv
src/register_file_alu_with_flags.sv
tb/sv/register_file_alu_with_flags_tb.sv
